// ----- sv/msps_pkg.sv -----
package msps_pkg;

  // field widths
  localparam int RPM_W   = 13;
  localparam int GAIN_W  = 8;
  localparam int DUTY_W  = 8;
  localparam int ERR_W   = 9;
  localparam int INTEG_W = 32;
  localparam int CFG_IDX_W = 3;

  // duty domain constants
  localparam int DUTY_SCALE    = 255;
  localparam int OVERSPEED_RPM = 5000;
  localparam int DUTY_MAX      = 200;
  localparam int START_DUTY    = 31;

  // x / 100 as (x * M) >> K, exact for x below 2**32
  localparam int          DIV100_K = 38;
  localparam logic [31:0] DIV100_M = 32'd2748779070;
  // same for short operands, exact for x below 2**15
  localparam int          DIV100S_K = 22;
  localparam logic [15:0] DIV100S_M = 16'd41944;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_PROP  = 3'd0,
    CFG_GAIN_INTEG = 3'd1,
    CFG_GAIN_DERIV = 3'd2,
    CFG_USE_PROP   = 3'd3,
    CFG_USE_INTEG  = 3'd4,
    CFG_USE_DERIV  = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_START,
    KIND_IDLE,
    KIND_DRIVE
  } kind_e;

  typedef struct packed {
    logic [RPM_W-1:0] measured_rpm;
    logic [RPM_W-1:0] target_rpm;
  } in_t;

  typedef struct packed {
    logic              drive_valid;
    logic [DUTY_W-1:0] duty;
    logic              start_tick;
  } out_t;

endpackage

// ----- sv/motor_speed_pid_step_unit.sv -----
// channel   direction  handshake                   payload
// ---------------------------------------------------------------------------
// input     in         in_valid_i / in_stall_o     in_data_i  (msps_pkg::in_t)
// output    out        out_valid_o / out_stall_i   out_data_o (msps_pkg::out_t)
// config    in         cfg_we_i                    cfg_idx_i, cfg_data_i
//
// one transaction per cycle sustained while the output is not stalled; each input
// transaction lands in stage 1 and moves stage by stage to stage 9, the output register
// the integral accumulator is a single saturating add, made on drive ticks, in stage 2
// reset clears all stage valid bits, the controller state and the gain registers
// a stalled output holds in the output register; empty stages keep filling, and
// in_stall_o rises only once every stage holds a transaction

module motor_speed_pid_step_unit #(
  parameter int FULL_SCALE_RPM = 6000
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  msps_pkg::in_t                        in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output msps_pkg::out_t                       out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [msps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [msps_pkg::GAIN_W-1:0]          cfg_data_i
);

  // rpm * 255 stays below 2**21; rpm * 255 / FULL_SCALE_RPM as multiply and shift
  localparam int SCL_N  = 21;
  localparam int SCL_K  = SCL_N + $clog2(FULL_SCALE_RPM);
  localparam int SCL_MW = SCL_N + 2;
  localparam logic [63:0] SCL_M64 =
    ((64'd1 << SCL_K) + 64'(FULL_SCALE_RPM) - 64'd1) / 64'(FULL_SCALE_RPM);
  localparam logic [SCL_MW-1:0] SCL_M = SCL_M64[SCL_MW-1:0];
  localparam int SCL_PW = SCL_N + SCL_MW;

  localparam int NSTG = 9;

  localparam int RW = msps_pkg::RPM_W;
  localparam int EW = msps_pkg::ERR_W;
  localparam int IW = msps_pkg::INTEG_W;
  localparam int GW = msps_pkg::GAIN_W;
  localparam int DW = msps_pkg::DUTY_W;

  // configuration registers
  logic [GW-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic          use_prop_q, use_integ_q, use_deriv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= '0;
      gain_integ_q <= '0;
      gain_deriv_q <= '0;
      use_prop_q   <= 1'b0;
      use_integ_q  <= 1'b0;
      use_deriv_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        msps_pkg::CFG_GAIN_PROP:  gain_prop_q  <= cfg_data_i;
        msps_pkg::CFG_GAIN_INTEG: gain_integ_q <= cfg_data_i;
        msps_pkg::CFG_GAIN_DERIV: gain_deriv_q <= cfg_data_i;
        msps_pkg::CFG_USE_PROP:   use_prop_q   <= cfg_data_i[0];
        msps_pkg::CFG_USE_INTEG:  use_integ_q  <= cfg_data_i[0];
        msps_pkg::CFG_USE_DERIV:  use_deriv_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline flow control: a stage loads when it is empty or its successor loads
  logic [NSTG-1:0] vld_q, vld_d, en;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || !out_stall_i;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int i = 1; i < NSTG; i++) begin
      vld_d[i] = en[i] ? vld_q[i-1] : vld_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  logic in_acc;
  assign in_acc     = in_valid_i && en[0];
  assign in_stall_o = !en[0];

  // start flag and setpoint tracking, updated in transaction order at the input
  logic          started_q;
  logic [RW-1:0] last_tgt_q;
  logic          tgt_chg;

  assign tgt_chg = (in_data_i.target_rpm != last_tgt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q  <= 1'b0;
      last_tgt_q <= '0;
    end else if (in_acc) begin
      started_q  <= 1'b1;
      last_tgt_q <= in_data_i.target_rpm;
    end
  end

  // ---------------- stage 1: input register, scale to duty domain ----------
  logic [RW-1:0] s1_meas_q, s1_tgt_q;
  logic          s1_clr_q, s1_start_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_meas_q  <= in_data_i.measured_rpm;
      s1_tgt_q   <= in_data_i.target_rpm;
      s1_clr_q   <= tgt_chg;
      s1_start_q <= !started_q;
    end
  end

  logic [SCL_N-1:0]  m255, t255;
  logic [SCL_PW-1:0] m_prod, t_prod;
  logic [RW-1:0]     m_quo, t_quo;
  logic [7:0]        m_sc, t_sc;
  logic signed [EW-1:0] s1_err;
  msps_pkg::kind_e   s1_kind;

  always_comb begin
    m255   = {s1_meas_q, 8'b0} - {8'b0, s1_meas_q};
    t255   = {s1_tgt_q, 8'b0} - {8'b0, s1_tgt_q};
    m_prod = SCL_PW'(m255) * SCL_PW'(SCL_M);
    t_prod = SCL_PW'(t255) * SCL_PW'(SCL_M);
    m_quo  = RW'(m_prod >> SCL_K);
    t_quo  = RW'(t_prod >> SCL_K);
    // saturate only matters for out-of-range speeds
    m_sc   = (m_quo > RW'(msps_pkg::DUTY_SCALE)) ? 8'(msps_pkg::DUTY_SCALE) : m_quo[7:0];
    t_sc   = (t_quo > RW'(msps_pkg::DUTY_SCALE)) ? 8'(msps_pkg::DUTY_SCALE) : t_quo[7:0];
    s1_err = $signed({1'b0, t_sc}) - $signed({1'b0, m_sc});
    if (s1_start_q) begin
      s1_kind = msps_pkg::KIND_START;
    end else if (s1_meas_q >= RW'(msps_pkg::OVERSPEED_RPM)) begin
      s1_kind = msps_pkg::KIND_IDLE;
    end else begin
      s1_kind = msps_pkg::KIND_DRIVE;
    end
  end

  // ---------------- stage 2: integral and previous error -------------------
  msps_pkg::kind_e      s2_kind_q;
  logic                 s2_clr_q;
  logic signed [EW-1:0] s2_err_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_kind_q <= s1_kind;
      s2_clr_q  <= s1_clr_q;
      s2_err_q  <= s1_err;
    end
  end

  logic signed [IW-1:0] integ_q, integ_d;
  logic signed [EW-1:0] prev_q, prev_d;
  logic signed [IW-1:0] base;
  logic signed [IW:0]   acc;
  logic signed [IW-1:0] acc_sat;
  logic signed [10:0]   s2_diff;

  always_comb begin
    base = s2_clr_q ? '0 : integ_q;
    acc  = (IW+1)'(base) + (IW+1)'(s2_err_q);
    if (acc[IW] != acc[IW-1]) begin
      acc_sat = acc[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
    end else begin
      acc_sat = acc[IW-1:0];
    end
    s2_diff = 11'(s2_err_q) - 11'(prev_q);
    if (s2_kind_q == msps_pkg::KIND_DRIVE) begin
      integ_d = acc_sat;
      prev_d  = s2_err_q;
    end else begin
      // setpoint change still clears the integral on start and overspeed ticks
      integ_d = base;
      prev_d  = prev_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (vld_q[1] && en[2]) begin
      integ_q <= integ_d;
      prev_q  <= prev_d;
    end
  end

  // ---------------- stage 3: proportional and derivative products ----------
  msps_pkg::kind_e      s3_kind_q;
  logic signed [EW-1:0] s3_err_q;
  logic signed [10:0]   s3_diff_q;
  logic signed [IW-1:0] s3_isum_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_kind_q <= s2_kind_q;
      s3_err_q  <= s2_err_q;
      s3_diff_q <= s2_diff;
      s3_isum_q <= acc_sat;
    end
  end

  logic [GW-1:0]        gp_eff, gd_eff;
  logic signed [17:0]   s3_pterm;
  logic signed [18:0]   s3_dprod;
  logic [IW-1:0]        s3_mag;

  always_comb begin
    gp_eff   = use_prop_q  ? gain_prop_q  : '0;
    gd_eff   = use_deriv_q ? gain_deriv_q : '0;
    s3_pterm = 18'($signed({1'b0, gp_eff})) * 18'(s3_err_q);
    s3_dprod = 19'($signed({1'b0, gd_eff})) * 19'(s3_diff_q);
    // magnitude of the most negative sum reads correctly as unsigned
    s3_mag   = s3_isum_q[IW-1] ? IW'(-s3_isum_q) : IW'(s3_isum_q);
  end

  // ---------------- stage 4: integral magnitude / 100, derivative * 100 ----
  msps_pkg::kind_e    s4_kind_q;
  logic signed [17:0] s4_pterm_q;
  logic signed [18:0] s4_dprod_q;
  logic [IW-1:0]      s4_mag_q;
  logic               s4_neg_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_kind_q  <= s3_kind_q;
      s4_pterm_q <= s3_pterm;
      s4_dprod_q <= s3_dprod;
      s4_mag_q   <= s3_mag;
      s4_neg_q   <= s3_isum_q[IW-1];
    end
  end

  logic [63:0]        s4_qprod;
  logic [25:0]        s4_quo;
  logic signed [25:0] s4_dx, s4_dterm;

  always_comb begin
    s4_qprod = 64'(s4_mag_q) * 64'(msps_pkg::DIV100_M);
    s4_quo   = 26'(s4_qprod >> msps_pkg::DIV100_K);
    s4_dx    = 26'(s4_dprod_q);
    s4_dterm = (s4_dx <<< 6) + (s4_dx <<< 5) + (s4_dx <<< 2);
  end

  // ---------------- stage 5: remainder of the integral division ------------
  msps_pkg::kind_e    s5_kind_q;
  logic signed [17:0] s5_pterm_q;
  logic signed [25:0] s5_dterm_q;
  logic [IW-1:0]      s5_mag_q;
  logic               s5_neg_q;
  logic [25:0]        s5_quo_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_kind_q  <= s4_kind_q;
      s5_pterm_q <= s4_pterm_q;
      s5_dterm_q <= s4_dterm;
      s5_mag_q   <= s4_mag_q;
      s5_neg_q   <= s4_neg_q;
      s5_quo_q   <= s4_quo;
    end
  end

  logic [IW-1:0] s5_q100;
  logic [6:0]    s5_rem;

  always_comb begin
    s5_q100 = IW'({s5_quo_q, 6'b0}) + IW'({s5_quo_q, 5'b0}) + IW'({s5_quo_q, 2'b0});
    s5_rem  = 7'(s5_mag_q - s5_q100);
  end

  // ---------------- stage 6: integral gain products ------------------------
  // gain * |sum| / 100 = gain * quo + (gain * rem) / 100
  msps_pkg::kind_e    s6_kind_q;
  logic signed [17:0] s6_pterm_q;
  logic signed [25:0] s6_dterm_q;
  logic               s6_neg_q;
  logic [25:0]        s6_quo_q;
  logic [6:0]         s6_rem_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_kind_q  <= s5_kind_q;
      s6_pterm_q <= s5_pterm_q;
      s6_dterm_q <= s5_dterm_q;
      s6_neg_q   <= s5_neg_q;
      s6_quo_q   <= s5_quo_q;
      s6_rem_q   <= s5_rem;
    end
  end

  logic [GW-1:0] gi_eff;
  logic [33:0]   s6_gq;
  logic [14:0]   s6_gr;

  always_comb begin
    gi_eff = use_integ_q ? gain_integ_q : '0;
    s6_gq  = 34'(gi_eff) * 34'(s6_quo_q);
    s6_gr  = 15'(gi_eff) * 15'(s6_rem_q);
  end

  // ---------------- stage 7: finish integral term, sum p and d -------------
  msps_pkg::kind_e    s7_kind_q;
  logic signed [17:0] s7_pterm_q;
  logic signed [25:0] s7_dterm_q;
  logic               s7_neg_q;
  logic [33:0]        s7_gq_q;
  logic [14:0]        s7_gr_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_kind_q  <= s6_kind_q;
      s7_pterm_q <= s6_pterm_q;
      s7_dterm_q <= s6_dterm_q;
      s7_neg_q   <= s6_neg_q;
      s7_gq_q    <= s6_gq;
      s7_gr_q    <= s6_gr;
    end
  end

  logic [31:0]        s7_grprod;
  logic [7:0]         s7_grq;
  logic [33:0]        s7_imag;
  logic signed [26:0] s7_pd;

  always_comb begin
    s7_grprod = 32'(s7_gr_q) * 32'(msps_pkg::DIV100S_M);
    s7_grq    = 8'(s7_grprod >> msps_pkg::DIV100S_K);
    s7_imag   = s7_gq_q + 34'(s7_grq);
    s7_pd     = 27'(s7_pterm_q) + 27'(s7_dterm_q);
  end

  // ---------------- stage 8: total drive and clamp -------------------------
  msps_pkg::kind_e    s8_kind_q;
  logic signed [26:0] s8_pd_q;
  logic               s8_neg_q;
  logic [33:0]        s8_imag_q;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s8_kind_q <= s7_kind_q;
      s8_pd_q   <= s7_pd;
      s8_neg_q  <= s7_neg_q;
      s8_imag_q <= s7_imag;
    end
  end

  logic signed [35:0] s8_iterm, s8_drive;
  logic [DW-1:0]      s8_duty;
  msps_pkg::out_t     s8_res;

  always_comb begin
    s8_iterm = $signed({2'b0, s8_imag_q});
    if (s8_neg_q) begin
      s8_iterm = -s8_iterm;
    end
    s8_drive = 36'(s8_pd_q) + s8_iterm;
    if (s8_drive < 0) begin
      s8_duty = '0;
    end else if (s8_drive > 36'(msps_pkg::DUTY_MAX)) begin
      s8_duty = DW'(msps_pkg::DUTY_MAX);
    end else begin
      s8_duty = s8_drive[DW-1:0];
    end
    case (s8_kind_q)
      msps_pkg::KIND_START: begin
        s8_res.drive_valid = 1'b1;
        s8_res.duty        = DW'(msps_pkg::START_DUTY);
        s8_res.start_tick  = 1'b1;
      end
      msps_pkg::KIND_DRIVE: begin
        s8_res.drive_valid = 1'b1;
        s8_res.duty        = s8_duty;
        s8_res.start_tick  = 1'b0;
      end
      default: begin
        // overspeed tick, no new drive
        s8_res.drive_valid = 1'b0;
        s8_res.duty        = '0;
        s8_res.start_tick  = 1'b0;
      end
    endcase
  end

  // ---------------- stage 9: output register -------------------------------
  msps_pkg::out_t out_q;

  always_ff @(posedge clk_i) begin
    if (en[8]) begin
      out_q <= s8_res;
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign out_data_o  = out_q;

endmodule

// ----- sv/msps_chk.sv -----
module msps_chk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_stall_o,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  msps_pkg::out_t                 out_data_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // input only backs up behind a stalled result
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output is free");

  a_start_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.start_tick |->
      out_data_o.drive_valid && out_data_o.duty == 8'(msps_pkg::START_DUTY))
    else $error("start tick without start duty");

  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.drive_valid |->
      out_data_o.duty == '0 && !out_data_o.start_tick)
    else $error("no-drive result carries data");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.drive_valid && !out_data_o.start_tick |->
      out_data_o.duty <= 8'(msps_pkg::DUTY_MAX))
    else $error("duty above limit");

endmodule

bind motor_speed_pid_step_unit msps_chk u_msps_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
